FILE: rtl/klt_pkg.sv
// ----------------------------------------------------------------------------
// klt_pkg
// Shared types and constants of the keyword lexer.
// ----------------------------------------------------------------------------
package klt_pkg;

  typedef enum logic [1:0] {
    REC_TOKEN = 2'd0,
    REC_BYTE  = 2'd1,
    REC_ERROR = 2'd2
  } rec_t;

  typedef enum logic [1:0] {
    ERR_UNEXPECTED   = 2'd0,
    ERR_UNTERMINATED = 2'd1,
    ERR_ESCAPE       = 2'd2
  } err_t;

  localparam logic [5:0] TK_EOF    = 6'd0;
  localparam logic [5:0] TK_IDENT  = 6'd1;
  localparam logic [5:0] TK_NUMBER = 6'd2;
  localparam logic [5:0] TK_STRING = 6'd3;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_type;
    logic [5:0]  token_kind;
    logic [1:0]  error_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] lexeme_length;
    logic        after_space;
    logic [7:0]  content_byte;
    logic        last_result;
  } out_item_t;

  // byte class of one input byte, computed in the front part
  typedef struct packed {
    logic blank;
    logic hash;
    logic digit;
    logic wstart;
    logic quote;
    logic bslash;
    logic dot;
    logic eq;
    logic cmp;      // = ! < >
    logic [5:0] single; // single-char operator kind, 0 if none
  } cls_t;

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    cls_t       c;
  } fq_item_t;

  function automatic logic [5:0] single_op(input logic [7:0] b);
    unique case (b)
      "+": single_op = 6'd11;
      "-": single_op = 6'd12;
      "*": single_op = 6'd13;
      "/": single_op = 6'd14;
      ";": single_op = 6'd27;
      ",": single_op = 6'd30;
      "(": single_op = 6'd28;
      ")": single_op = 6'd29;
      "[": single_op = 6'd36;
      "]": single_op = 6'd37;
      "|": single_op = 6'd44;
      "%": single_op = 6'd48;
      default: single_op = 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] cmp_kind(input logic [7:0] op, input logic dbl);
    unique case (op)
      "=": cmp_kind = dbl ? 6'd16 : 6'd15;
      "!": cmp_kind = dbl ? 6'd18 : 6'd25;
      "<": cmp_kind = dbl ? 6'd20 : 6'd19;
      default: cmp_kind = dbl ? 6'd22 : 6'd21;
    endcase
  endfunction

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    c.blank  = (b == 8'h20) || (b == 8'h0d) || (b == 8'h09) || (b == 8'h0a);
    c.hash   = (b == "#");
    c.digit  = (b >= "0") && (b <= "9");
    c.wstart = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
               (b == "_") || b[7];
    c.quote  = (b == 8'h22);
    c.bslash = (b == 8'h5c);
    c.dot    = (b == ".");
    c.eq     = (b == "=");
    c.cmp    = (b == "=") || (b == "!") || (b == "<") || (b == ">");
    c.single = single_op(b);
    return c;
  endfunction

  localparam int unsigned KW_N   = 55;
  localparam int unsigned KW_LEN = 11;

  typedef struct packed {
    logic [KW_LEN*8-1:0] text; // byte 0 at the low end
    logic [3:0]          len;
    logic [5:0]          kind;
  } kw_t;

  function automatic logic [KW_LEN*8-1:0] kwtxt(input string s);
    logic [KW_LEN*8-1:0] t;
    t = '0;
    for (int i = 0; i < KW_LEN; i++) begin
      if (i < s.len()) t[i*8 +: 8] = s[i];
    end
    return t;
  endfunction

  function automatic kw_t kw(input string s, input int k);
    kw_t e;
    e.text = kwtxt(s);
    e.len  = 4'(s.len());
    e.kind = 6'(k);
    return e;
  endfunction

  function automatic kw_t kw_entry(input int unsigned i);
    unique case (i)
      0: return kw("mitte", 4);       1: return kw("metti", 4);
      2: return kw("remette", 4);     3: return kw("variabile", 4);
      4: return kw("dicce", 5);       5: return kw("di", 5);
      6: return kw("scrive", 5);      7: return kw("stampa", 5);
      8: return kw("se", 6);          9: return kw("altrimenti", 7);
      10: return kw("firmete", 8);    11: return kw("vale", 26);
      12: return kw("diventa", 26);   13: return kw("piu", 11);
      14: return kw("meno", 12);      15: return kw("pe", 13);
      16: return kw("scumpunne", 14); 17: return kw("uguale", 16);
      18: return kw("de", 17);        19: return kw("diverse", 18);
      20: return kw("meno_de", 19);   21: return kw({"meno_", "uguale"}, 20);
      22: return kw("piu_de", 21);    23: return kw({"piu_", "uguale"}, 22);
      24: return kw("e", 23);         25: return kw("o", 24);
      26: return kw("ne", 25);        27: return kw("sci", 9);
      28: return kw("vero", 9);       29: return kw("no", 10);
      30: return kw("falso", 10);     31: return kw("quinde", 31);
      32: return kw("tornete", 32);   33: return kw("mbe", 33);
      34: return kw("po", 35);        35: return kw("prime", 38);
      36: return kw("uldeme", 39);    37: return kw("vute", 40);
      38: return kw("mitta", 41);     39: return kw("simele", 42);
      40: return kw("cusci", 43);     41: return kw("damme", 45);
      42: return kw("numere", 46);    43: return kw("quante", 47);
      44: return kw("spezza", 49);    45: return kw("iecch", 50);
      46: return kw("cala", 51);      47: return kw("suva", 52);
      48: return kw("arretunne", 53); 49: return kw("radice", 54);
      50: return kw("quadrata", 55);  51: return kw("vabbone", 56);
      52: return kw("guaje", 57);     53: return kw("prove", 58);
      default: return kw("dove", 59);
    endcase
  endfunction

endpackage

FILE: rtl/klt_front.sv
// ----------------------------------------------------------------------------
// klt_front
// Input stage: takes source words, classifies each byte, and keeps a
// two-entry queue toward the scanner.
// ----------------------------------------------------------------------------
module klt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  klt_pkg::in_item_t   in_item,
  output logic                fq_valid,
  output klt_pkg::fq_item_t   fq_item,
  input  logic                fq_take
);
  import klt_pkg::*;

  fq_item_t   q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push_ok, take_ok;
  fq_item_t   w;

  assign in_full  = (cnt_r == 2'd2);
  assign fq_valid = (cnt_r != 2'd0);
  assign fq_item  = q_r[rd_r];
  assign push_ok  = in_push && !in_full;
  assign take_ok  = fq_take && fq_valid;

  always_comb begin
    w.b   = in_item.source_byte;
    w.eos = in_item.end_of_source;
    w.c   = classify(in_item.source_byte);
    cnt_nxt = cnt_r + 2'(push_ok) - 2'(take_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_ok) wr_r <= !wr_r;
      if (take_ok) rd_r <= !rd_r;
    end
    if (push_ok) q_r[wr_r] <= w;
  end
endmodule

FILE: rtl/klt_back.sv
// ----------------------------------------------------------------------------
// klt_back
// Scanner: runs the lexer state per byte and writes up to two result words
// per byte into the output queue.
// ----------------------------------------------------------------------------
module klt_back #(
  parameter int unsigned KEYWORD_MAX_LEN = 12,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fq_valid,
  input  klt_pkg::fq_item_t  fq_item,
  output logic               fq_take,
  output logic               out_empty,
  input  logic               out_pop,
  output klt_pkg::out_item_t out_item
);
  import klt_pkg::*;

  typedef enum logic [9:0] {
    M_IDLE    = 10'b0000000001,
    M_COMMENT = 10'b0000000010,
    M_OP      = 10'b0000000100,
    M_IDENT   = 10'b0000001000,
    M_INT     = 10'b0000010000,
    M_DOT     = 10'b0000100000,
    M_FRAC    = 10'b0001000000,
    M_STR     = 10'b0010000000,
    M_ESC     = 10'b0100000000,
    M_DRAIN   = 10'b1000000000
  } mode_t;

  localparam int unsigned PB = POSITION_BITS;
  localparam logic [PB-1:0] PMAX = '1;
  localparam logic [PB-1:0] PONE = PB'(1);
  localparam logic [15:0]   LMAX = 16'hffff;
  localparam int unsigned WIB = $clog2(KEYWORD_MAX_LEN);
  localparam int unsigned OQD = 4;

  mode_t mode_r, mode_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  wb_r [KEYWORD_MAX_LEN];
  logic [15:0] tlen_r, tlen_nxt;
  logic [PB-1:0] cl_r, cl_nxt, cc_r, cc_nxt, tl_r, tl_nxt, tc_r, tc_nxt;
  logic trivia_r, trivia_nxt;
  logic wb_we;
  logic [WIB-1:0] wb_idx;
  logic [7:0] wb_d;

  // output queue
  out_item_t   oq_r [OQD];
  logic [1:0]  ord_r, owr_r;
  logic [2:0]  ocnt_r;
  logic        room;
  logic [1:0]  n_res;
  out_item_t   r0, r1, res0, res1;

  logic [7:0] b;
  cls_t c;
  logic [5:0] wkind;

  function automatic logic [PB-1:0] padd(input logic [PB-1:0] a, input logic [PB-1:0] d);
    logic [PB:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[PB] ? PMAX : s[PB-1:0];
  endfunction

  function automatic logic [15:0] ladd(input logic [15:0] a, input logic [15:0] d);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, d};
    return s[16] ? LMAX : s[15:0];
  endfunction

  function automatic out_item_t mk(input rec_t t, input logic [5:0] k, input err_t e,
                                   input logic [PB-1:0] l, input logic [PB-1:0] cc,
                                   input logic [15:0] len, input logic sp,
                                   input logic [7:0] by);
    out_item_t o;
    o.record_type   = t;
    o.token_kind    = k;
    o.error_kind    = e;
    o.start_line    = 16'(l);
    o.start_column  = 16'(cc);
    o.lexeme_length = len;
    o.after_space   = sp;
    o.content_byte  = by;
    o.last_result   = 1'b0;
    return o;
  endfunction

  // parallel keyword compare of the buffered word
  always_comb begin
    logic hit;
    logic [7:0] ch;
    wkind = TK_IDENT;
    for (int i = 0; i < KW_N; i++) begin
      kw_t e;
      e = kw_entry(i);
      hit = (tlen_r == 16'(e.len));
      for (int k = 0; k < KW_LEN; k++) begin
        ch = (k < KEYWORD_MAX_LEN) ? wb_r[k] : 8'h00;
        if (k < e.len && ch != e.text[k*8 +: 8]) hit = 1'b0;
      end
      if (hit) wkind = e.kind;
    end
  end

  assign b = fq_item.b;
  assign c = fq_item.c;
  assign room = (ocnt_r <= 3'(OQD - 2));
  assign fq_take = fq_valid && room;

  always_comb begin
    logic tok_pending;   // token emitted ahead of idle handling
    logic do_idle;
    logic [PB-1:0] ncc, ncl;
    logic [15:0] nl;
    logic [7:0] dec;
    mode_nxt = mode_r; pend_nxt = pend_r; tlen_nxt = tlen_r;
    cl_nxt = cl_r; cc_nxt = cc_r; tl_nxt = tl_r; tc_nxt = tc_r;
    trivia_nxt = trivia_r;
    wb_we = 1'b0; wb_idx = '0; wb_d = b;
    n_res = 2'd0;
    r0 = '0; r1 = '0;
    do_idle = 1'b0;
    tok_pending = 1'b0;
    dec = 8'h00;
    // advance by this byte
    ncl = (b == 8'h0a) ? padd(cl_r, PONE) : cl_r;
    ncc = (b == 8'h0a) ? PONE : padd(cc_r, PONE);
    nl  = ladd(tlen_r, 16'd1);

    if (fq_item.eos) begin
      logic eof;
      eof = 1'b1;
      unique case (mode_r)
        M_OP: begin
          r0 = mk(REC_TOKEN, cmp_kind(pend_r, 1'b0), ERR_UNEXPECTED, tl_r, tc_r,
                  16'd1, trivia_r, 8'h00);
          n_res = 2'd1; trivia_nxt = 1'b0;
        end
        M_IDENT: begin
          r0 = mk(REC_TOKEN, (tlen_r > 16'(KEYWORD_MAX_LEN)) ? TK_IDENT : wkind,
                  ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
          n_res = 2'd1; trivia_nxt = 1'b0;
        end
        M_INT, M_FRAC: begin
          r0 = mk(REC_TOKEN, TK_NUMBER, ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
          n_res = 2'd1; trivia_nxt = 1'b0;
        end
        M_DOT: begin
          r0 = mk(REC_TOKEN, TK_NUMBER, ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
          r1 = mk(REC_ERROR, TK_EOF, ERR_UNEXPECTED, tl_r, padd(tc_r, PB'(tlen_r)),
                  16'd0, 1'b0, 8'h00);
          n_res = 2'd2; eof = 1'b0;
        end
        M_STR, M_ESC: begin
          r0 = mk(REC_ERROR, TK_EOF, ERR_UNTERMINATED, tl_r, tc_r, 16'd0, 1'b0, 8'h00);
          n_res = 2'd1; eof = 1'b0;
        end
        M_DRAIN: eof = 1'b0;
        default: ;
      endcase
      if (eof) begin
        if (n_res == 2'd1) begin
          r1 = mk(REC_TOKEN, TK_EOF, ERR_UNEXPECTED, cl_r, cc_r, 16'd0, 1'b0, 8'h00);
          n_res = 2'd2;
        end else begin
          r0 = mk(REC_TOKEN, TK_EOF, ERR_UNEXPECTED, cl_r, cc_r, 16'd0, trivia_r, 8'h00);
          n_res = 2'd1;
        end
      end
      mode_nxt = M_IDLE; pend_nxt = '0; tlen_nxt = '0;
      cl_nxt = PONE; cc_nxt = PONE; tl_nxt = PONE; tc_nxt = PONE; trivia_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        M_COMMENT: begin
          cl_nxt = ncl; cc_nxt = ncc;
          if (b == 8'h0a) mode_nxt = M_IDLE;
        end
        M_OP: begin
          if (c.eq) begin
            cl_nxt = ncl; cc_nxt = ncc; mode_nxt = M_IDLE;
            r0 = mk(REC_TOKEN, cmp_kind(pend_r, 1'b1), ERR_UNEXPECTED, tl_r, tc_r,
                    16'd2, trivia_r, 8'h00);
            n_res = 2'd1; trivia_nxt = 1'b0;
          end else begin
            r0 = mk(REC_TOKEN, cmp_kind(pend_r, 1'b0), ERR_UNEXPECTED, tl_r, tc_r,
                    16'd1, trivia_r, 8'h00);
            tok_pending = 1'b1; do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (c.wstart || c.digit) begin
            cl_nxt = ncl; cc_nxt = ncc;
            if (tlen_r < 16'(KEYWORD_MAX_LEN)) begin
              wb_we = 1'b1; wb_idx = WIB'(tlen_r);
            end
            tlen_nxt = nl;
          end else begin
            r0 = mk(REC_TOKEN, (tlen_r > 16'(KEYWORD_MAX_LEN)) ? TK_IDENT : wkind,
                    ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
            tok_pending = 1'b1; do_idle = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (c.digit) begin
            cl_nxt = ncl; cc_nxt = ncc; tlen_nxt = nl;
          end else if (c.dot && mode_r == M_INT) begin
            cl_nxt = ncl; cc_nxt = ncc; mode_nxt = M_DOT;
          end else begin
            r0 = mk(REC_TOKEN, TK_NUMBER, ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
            tok_pending = 1'b1; do_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (c.digit) begin
            cl_nxt = ncl; cc_nxt = ncc; tlen_nxt = ladd(tlen_r, 16'd2); mode_nxt = M_FRAC;
          end else begin
            r0 = mk(REC_TOKEN, TK_NUMBER, ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
            r1 = mk(REC_ERROR, TK_EOF, ERR_UNEXPECTED, tl_r, padd(tc_r, PB'(tlen_r)),
                    16'd0, 1'b0, 8'h00);
            n_res = 2'd2; trivia_nxt = 1'b0; mode_nxt = M_DRAIN;
          end
        end
        M_STR: begin
          cl_nxt = ncl; cc_nxt = ncc;
          if (c.quote) begin
            mode_nxt = M_IDLE;
            r0 = mk(REC_TOKEN, TK_STRING, ERR_UNEXPECTED, tl_r, tc_r, tlen_r, trivia_r, 8'h00);
            n_res = 2'd1; trivia_nxt = 1'b0;
          end else if (c.bslash) begin
            mode_nxt = M_ESC;
          end else begin
            tlen_nxt = nl;
            r0 = mk(REC_BYTE, TK_EOF, ERR_UNEXPECTED, tl_r, tc_r, nl, 1'b0, b);
            n_res = 2'd1;
          end
        end
        M_ESC: begin
          cl_nxt = ncl; cc_nxt = ncc;
          priority if (b == "n") dec = 8'h0a;
          else if (b == "t") dec = 8'h09;
          else if (c.quote || c.bslash) dec = b;
          else dec = 8'h00;
          if (dec != 8'h00) begin
            mode_nxt = M_STR; tlen_nxt = nl;
            r0 = mk(REC_BYTE, TK_EOF, ERR_UNEXPECTED, tl_r, tc_r, nl, 1'b0, dec);
          end else begin
            mode_nxt = M_DRAIN;
            r0 = mk(REC_ERROR, TK_EOF, ERR_ESCAPE, ncl, ncc, 16'd0, 1'b0, 8'h00);
          end
          n_res = 2'd1;
        end
        M_DRAIN: ;
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        out_item_t t;
        logic emit;
        logic sp;
        sp = tok_pending ? 1'b0 : trivia_r;
        trivia_nxt = sp;
        mode_nxt = M_IDLE;
        cl_nxt = ncl; cc_nxt = ncc;
        emit = 1'b0;
        t = '0;
        if (c.blank) begin
          trivia_nxt = 1'b1;
        end else if (c.hash) begin
          trivia_nxt = 1'b1; mode_nxt = M_COMMENT;
        end else begin
          tl_nxt = cl_r; tc_nxt = cc_r;
          if (c.single != 6'd0) begin
            t = mk(REC_TOKEN, c.single, ERR_UNEXPECTED, cl_r, cc_r, 16'd1, sp, 8'h00);
            emit = 1'b1; trivia_nxt = 1'b0;
          end else if (c.cmp) begin
            pend_nxt = b; mode_nxt = M_OP;
          end else if (c.quote) begin
            tlen_nxt = '0; mode_nxt = M_STR;
          end else if (c.digit) begin
            tlen_nxt = 16'd1; mode_nxt = M_INT;
          end else if (c.wstart) begin
            wb_we = 1'b1; wb_idx = '0; tlen_nxt = 16'd1; mode_nxt = M_IDENT;
          end else begin
            t = mk(REC_ERROR, TK_EOF, ERR_UNEXPECTED, cl_r, cc_r, 16'd0, 1'b0, 8'h00);
            emit = 1'b1; mode_nxt = M_DRAIN;
          end
        end
        if (tok_pending) begin
          r1 = t;
          n_res = emit ? 2'd2 : 2'd1;
        end else begin
          r0 = t;
          n_res = emit ? 2'd1 : 2'd0;
        end
      end
    end

    res0 = r0; res1 = r1;
    if (n_res == 2'd1) res0.last_result = 1'b1;
    if (n_res == 2'd2) res1.last_result = 1'b1;
  end

  logic pop_ok;
  assign out_empty = (ocnt_r == 3'd0);
  assign out_item  = oq_r[ord_r];
  assign pop_ok    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; pend_r <= '0; tlen_r <= '0;
      cl_r <= PONE; cc_r <= PONE; tl_r <= PONE; tc_r <= PONE; trivia_r <= 1'b0;
      ord_r <= '0; owr_r <= '0; ocnt_r <= '0;
    end else begin
      if (fq_take) begin
        mode_r <= mode_nxt; pend_r <= pend_nxt; tlen_r <= tlen_nxt;
        cl_r <= cl_nxt; cc_r <= cc_nxt; tl_r <= tl_nxt; tc_r <= tc_nxt;
        trivia_r <= trivia_nxt;
        owr_r <= owr_r + (fq_take ? n_res : 2'd0);
      end
      if (pop_ok) ord_r <= ord_r + 2'd1;
      ocnt_r <= ocnt_r + 3'(fq_take ? n_res : 2'd0) - 3'(pop_ok);
    end
    if (fq_take) begin
      if (n_res != 2'd0) oq_r[owr_r] <= res0;
      if (n_res == 2'd2) oq_r[owr_r + 2'd1] <= res1;
      if (wb_we) wb_r[wb_idx] <= wb_d;
    end
  end
endmodule

FILE: rtl/keyword_lexer_tokenizer.sv
// ----------------------------------------------------------------------------
// keyword_lexer_tokenizer
// Byte-stream lexer with keyword lookup, string decoding and error drain.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_item and raise in_push while in_full is low; one
//   source byte (or an end-of-source marker) per word, one per cycle.
//   Result queue: while out_empty is low, out_item holds the oldest result;
//   raise out_pop to take it. Each input gives zero, one or two results, the
//   last one flagged by last_result.
//   Path: each byte is registered in the input queue; the scanner takes it
//   once the result queue has room and writes its results into the result
//   queue, whose oldest entry drives out_item.
//   Throughput: one byte per cycle while the result queue has room, with
//   a combinational scanner step and parallel keyword compare; two results
//   per byte drain at one per cycle, so the input then backs up the queues.
//   A stalled receiver backs up the four-entry result queue, then the scanner
//   stops and the two-entry input queue raises in_full; nothing is lost.
//   Reset (synchronous, rst_n low) empties both queues and returns the
//   scanner to line 1, column 1, between tokens.
// ----------------------------------------------------------------------------
module keyword_lexer_tokenizer #(
  parameter int unsigned KEYWORD_MAX_LEN = 12,
  parameter int unsigned POSITION_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  klt_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output klt_pkg::out_item_t out_item
);
  import klt_pkg::*;

  logic      fq_valid, fq_take;
  fq_item_t  fq_item;

  klt_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_item,
    .fq_valid, .fq_item, .fq_take
  );

  klt_back #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk, .rst_n, .fq_valid, .fq_item, .fq_take,
    .out_empty, .out_pop, .out_item
  );

  a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fq_take |-> fq_valid) else $error("scanner took from empty queue");

  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_item.record_type != 2'd3)) else $error("bad record type");

  a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !fq_take) |=> in_full) else $error("input queue lost a word");
endmodule
